### design/hlc_pkg.sv
// ----------------------------------------------------------------------------
// hlc_pkg: shared types and constants of the homogeneous line clip unit
// Widths of coordinates, crossing parameters and the records that pass
// from the classifying front end to the clipping back end.
// ----------------------------------------------------------------------------
package hlc_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int NAXES   = 3;

    // Numerators and denominators after two additions of coordinates.
    localparam int NUM_W = COORD_W + 2;
    // Quotient magnitude below two: one integer bit and the fraction bits.
    localparam int QT_W = FRAC_W + 1;
    // Signed crossing parameter, saturated to plus or minus two.
    localparam int T_W = FRAC_W + 3;
    // Divider register stages: operand stage, first quotient bit, fraction bits, output.
    localparam int DIV_LAT = FRAC_W + 3;

    localparam int IN_W  = 8 * COORD_W;
    localparam int OUT_W = ((1 + 2 * QT_W + 7) / 8) * 8;

    localparam logic [QT_W-1:0] T_ONE = QT_W'(1) << FRAC_W;

    typedef struct packed {
        logic in1;
        logic in2;
        logic para;
    } axis_flag_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] num_a;
        logic signed [NUM_W-1:0] num_b;
        logic signed [NUM_W-1:0] den_a;
        logic signed [NUM_W-1:0] den_b;
        axis_flag_t              flags;
    } axis_cls_t;

    typedef axis_cls_t [NAXES-1:0] seg_cls_t;
    typedef axis_flag_t [NAXES-1:0] seg_flag_t;

endpackage

### design/homogeneous_line_clip_unit.sv
// ----------------------------------------------------------------------------
// homogeneous_line_clip_unit: clips a homogeneous line segment to the view volume
// Reports visibility and the start and end parameters of the visible part.
// ----------------------------------------------------------------------------
// Usage:
// A segment enters as one transaction on the s_ channel: eight signed Q16.16
// coordinates, first point x, y, z, w then second point x, y, z, w.
// One result transaction leaves on the m_ channel per segment, in order:
// visible, then t_start and t_end as unsigned Q1.16 (zero when not visible).
// The block takes one segment per cycle while the queue has room. A segment
// passes 23 register stages: the input register, the queue, 19 stages of the
// pipelined dividers (an operand stage, one quotient bit a stage, an output
// stage), one stage of per-axis clipping and the output register.
// The front end classifies segments into a four-entry queue; when the
// receiver stalls, the back end pipeline holds and the queue fills, and
// s_tready falls only once the queue and the input register are full.
// Reset clears all valid state; no item is in flight afterward.
// ----------------------------------------------------------------------------
module homogeneous_line_clip_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // first_x, first_y, first_z, first_w, second_x, second_y, second_z, second_w
    input  logic [hlc_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // visible, t_start, t_end, zero fill
    output logic [hlc_pkg::OUT_W-1:0] m_tdata
);

    logic              push;
    logic              push_ready;
    hlc_pkg::seg_cls_t push_data;
    logic              pop;
    logic              pop_valid;
    hlc_pkg::seg_cls_t pop_data;

    hlc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    hlc_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    hlc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### design/hlc_front.sv
// ----------------------------------------------------------------------------
// hlc_front: input stage and classifier
// Registers one segment and derives, per axis, the inside flags, the
// parallel flag and the numerators and denominators of both crossings.
// ----------------------------------------------------------------------------
module hlc_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [hlc_pkg::IN_W-1:0] s_tdata,
    output logic                     push,
    input  logic                     push_ready,
    output hlc_pkg::seg_cls_t        push_data
);

    localparam int EXT_W = hlc_pkg::NUM_W - hlc_pkg::COORD_W;

    logic                     vld_reg;
    logic                     vld_next;
    logic [hlc_pkg::IN_W-1:0] seg_reg;

    assign s_tready = !vld_reg || push_ready;
    assign push     = vld_reg && push_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (s_tvalid && s_tready)
        begin
            vld_next = 1'b1;
        end
        else if (push)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            seg_reg <= s_tdata;
        end
    end

    function automatic logic signed [hlc_pkg::NUM_W-1:0] coord(input int idx,
        input logic [hlc_pkg::IN_W-1:0] seg);
        logic [hlc_pkg::COORD_W-1:0] c;
        c = seg[idx*hlc_pkg::COORD_W +: hlc_pkg::COORD_W];
        return {{EXT_W{c[hlc_pkg::COORD_W-1]}}, c};
    endfunction

    function automatic logic [hlc_pkg::NUM_W-1:0] mag(
        input logic signed [hlc_pkg::NUM_W-1:0] v);
        return v[hlc_pkg::NUM_W-1] ? hlc_pkg::NUM_W'(-v) : v;
    endfunction

    always_comb
    begin
        logic signed [hlc_pkg::NUM_W-1:0] w1;
        logic signed [hlc_pkg::NUM_W-1:0] w2;
        logic signed [hlc_pkg::NUM_W-1:0] d1;
        logic signed [hlc_pkg::NUM_W-1:0] d2;
        logic signed [hlc_pkg::NUM_W-1:0] dd;
        logic signed [hlc_pkg::NUM_W-1:0] dw;
        w1 = coord(3, seg_reg);
        w2 = coord(7, seg_reg);
        dw = w2 - w1;
        for (int a = 0; a < hlc_pkg::NAXES; a++)
        begin
            d1 = coord(a, seg_reg);
            d2 = coord(4 + a, seg_reg);
            dd = d2 - d1;
            push_data[a].num_a     = w1 - d1;
            push_data[a].num_b     = -w1 - d1;
            push_data[a].den_a     = dd - dw;
            push_data[a].den_b     = dd + dw;
            push_data[a].flags.in1 = mag(d1) <= mag(w1);
            push_data[a].flags.in2 = mag(d2) <= mag(w2);
            push_data[a].flags.para = (dd == dw) || (dd == -dw);
        end
    end

endmodule

### design/hlc_fifo.sv
// ----------------------------------------------------------------------------
// hlc_fifo: short queue of classified segments
// Four entries of flops between front and back end; the head is read
// combinationally.
// ----------------------------------------------------------------------------
module hlc_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              push_ready,
    input  hlc_pkg::seg_cls_t push_data,
    input  logic              pop,
    output logic              pop_valid,
    output hlc_pkg::seg_cls_t pop_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    hlc_pkg::seg_cls_t mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;

    assign push_ready = count_reg != (PTR_W+1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/hlc_div.sv
// ----------------------------------------------------------------------------
// hlc_div: pipelined restoring divider
// Signed quotient with the fraction bits of a crossing parameter, truncated
// toward zero and saturated to plus or minus two; one quotient bit a stage.
// ----------------------------------------------------------------------------
module hlc_div
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [hlc_pkg::NUM_W-1:0]    num,
    input  logic signed [hlc_pkg::NUM_W-1:0]    den,
    output logic signed [hlc_pkg::T_W-1:0]      quo
);

    localparam int MW = hlc_pkg::NUM_W;
    localparam int NS = hlc_pkg::FRAC_W;
    localparam int QW = hlc_pkg::QT_W;
    localparam int TW = hlc_pkg::T_W;

    logic [MW-1:0] n_a_reg;
    logic [MW-1:0] m_a_reg;
    logic          neg_a_reg;

    logic [MW-1:0] r_reg   [NS+1];
    logic [MW-1:0] m_reg   [NS+1];
    logic [QW-1:0] q_reg   [NS+1];
    logic          neg_reg [NS+1];
    logic          sat_reg [NS+1];

    logic [MW:0]   r2     [NS];
    logic          ge     [NS];
    logic [MW:0]   r2_sub [NS];

    logic [TW-1:0] mag;

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            r2[i]     = {r_reg[i], 1'b0};
            ge[i]     = r2[i] >= {1'b0, m_reg[i]};
            r2_sub[i] = r2[i] - {1'b0, m_reg[i]};
        end
    end

    assign mag = sat_reg[NS] ? (TW'(1) << (NS + 1)) : TW'(q_reg[NS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_a_reg   <= num[MW-1] ? MW'(-num) : num;
            m_a_reg   <= den[MW-1] ? MW'(-den) : den;
            neg_a_reg <= num[MW-1] != den[MW-1];

            sat_reg[0] <= {1'b0, n_a_reg} >= {m_a_reg, 1'b0};
            q_reg[0]   <= QW'(n_a_reg >= m_a_reg);
            r_reg[0]   <= (n_a_reg >= m_a_reg) ? n_a_reg - m_a_reg : n_a_reg;
            m_reg[0]   <= m_a_reg;
            neg_reg[0] <= neg_a_reg;

            for (int i = 1; i <= NS; i++)
            begin
                r_reg[i]   <= ge[i-1] ? r2_sub[i-1][MW-1:0] : r2[i-1][MW-1:0];
                q_reg[i]   <= {q_reg[i-1][QW-2:0], ge[i-1]};
                m_reg[i]   <= m_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
            end

            quo <= neg_reg[NS] ? -$signed(mag) : $signed(mag);
        end
    end

endmodule

### design/hlc_back.sv
// ----------------------------------------------------------------------------
// hlc_back: crossing division, per-axis clipping and interval merge
// Six dividers run in lock step; the whole pipeline holds while the
// output register is full and not taken.
// ----------------------------------------------------------------------------
module hlc_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    input  hlc_pkg::seg_cls_t         pop_data,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [hlc_pkg::OUT_W-1:0] m_tdata
);

    localparam int TW = hlc_pkg::T_W;
    localparam int QW = hlc_pkg::QT_W;
    localparam int NA = hlc_pkg::NAXES;
    localparam int LAT = hlc_pkg::DIV_LAT;
    localparam logic signed [TW-1:0] ZERO_S = '0;
    localparam logic signed [TW-1:0] ONE_S  = TW'(hlc_pkg::T_ONE);

    typedef struct packed {
        logic          ok;
        logic [QW-1:0] s;
        logic [QW-1:0] e;
    } axis_res_t;

    logic                   en;
    logic                   vld_reg  [LAT];
    hlc_pkg::seg_flag_t     flag_reg [LAT];
    logic signed [TW-1:0]   ta [NA];
    logic signed [TW-1:0]   tb [NA];
    logic                   ax_vld_reg;
    axis_res_t              ax_reg [NA];
    logic                   out_vld_reg;
    logic                   visible_reg;
    logic [QW-1:0]          ts_reg;
    logic [QW-1:0]          te_reg;
    logic [QW-1:0]          ts_next;
    logic [QW-1:0]          te_next;
    logic                   vis_next;

    assign en  = !out_vld_reg || m_tready;
    assign pop = en && pop_valid;

    for (genvar a = 0; a < NA; a++)
    begin : g_axis
        hlc_div u_div_a
        (
            .clk (clk),
            .en  (en),
            .num (pop_data[a].num_a),
            .den (pop_data[a].den_a),
            .quo (ta[a])
        );
        hlc_div u_div_b
        (
            .clk (clk),
            .en  (en),
            .num (pop_data[a].num_b),
            .den (pop_data[a].den_b),
            .quo (tb[a])
        );
    end

    function automatic axis_res_t axis_eval(input logic signed [TW-1:0] pa,
        input logic signed [TW-1:0] pb, input hlc_pkg::axis_flag_t fl);
        axis_res_t             res;
        logic signed [TW-1:0]  lo;
        logic signed [TW-1:0]  hi;
        logic signed [TW-1:0]  b;
        res.ok = 1'b1;
        res.s  = '0;
        res.e  = hlc_pkg::T_ONE;
        lo = (pa < pb) ? pa : pb;
        hi = (pa < pb) ? pb : pa;
        b  = (lo >= ZERO_S) ? lo : hi;
        if (fl.in1 && fl.in2)
        begin
            res.ok = 1'b1;
        end
        else if (fl.para)
        begin
            res.ok = fl.in1;
        end
        else if (lo >= ZERO_S && hi <= ONE_S)
        begin
            res.s = lo[QW-1:0];
            res.e = hi[QW-1:0];
        end
        else if (hi <= ZERO_S || lo >= ONE_S || (lo <= ZERO_S && hi >= ONE_S))
        begin
            res.ok = fl.in1;
        end
        else if (fl.in1)
        begin
            res.e = b[QW-1:0];
        end
        else
        begin
            res.s = b[QW-1:0];
        end
        return res;
    endfunction

    // Intersection of the three axis intervals.
    always_comb
    begin
        ts_next  = '0;
        te_next  = hlc_pkg::T_ONE;
        vis_next = 1'b1;
        for (int a = 0; a < NA; a++)
        begin
            if (!ax_reg[a].ok)
            begin
                vis_next = 1'b0;
            end
            if (ax_reg[a].s > ts_next)
            begin
                ts_next = ax_reg[a].s;
            end
            if (ax_reg[a].e < te_next)
            begin
                te_next = ax_reg[a].e;
            end
        end
        if (ts_next > te_next)
        begin
            vis_next = 1'b0;
        end
        if (!vis_next)
        begin
            ts_next = '0;
            te_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            ax_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= pop_valid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            ax_vld_reg  <= vld_reg[LAT-1];
            out_vld_reg <= ax_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NA; a++)
            begin
                flag_reg[0][a] <= pop_data[a].flags;
                ax_reg[a]      <= axis_eval(ta[a], tb[a], flag_reg[LAT-1][a]);
            end
            for (int i = 1; i < LAT; i++)
            begin
                flag_reg[i] <= flag_reg[i-1];
            end
            visible_reg <= vis_next;
            ts_reg      <= ts_next;
            te_reg      <= te_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = hlc_pkg::OUT_W'({te_reg, ts_reg, visible_reg});

endmodule

### tb/line_clip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_clip_checker: predicts and checks clip results of the line clip unit
// Watches both channels, computes the expected visibility and parameter range
// of every accepted segment, and compares each result transaction in order.
// ----------------------------------------------------------------------------
module line_clip_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [hlc_pkg::IN_W-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [hlc_pkg::OUT_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        pending,
    output int                        checked
);

    localparam longint ONE = longint'(1) << hlc_pkg::FRAC_W;
    localparam int QW = hlc_pkg::QT_W;
    localparam int CW = hlc_pkg::COORD_W;

    // Field order follows the result bus: visible in the lowest bit.
    typedef struct packed {
        logic [QW-1:0] t_hi;
        logic [QW-1:0] t_lo;
        logic          vis;
    } clip_result_t;

    clip_result_t expected_clips[$];

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Truncated quotient with the fraction bits of a parameter, saturated to two.
    function automatic longint crossing(longint num, longint den);
        longint n;
        longint m;
        longint q;
        n = magnitude(num);
        m = magnitude(den);
        if (n >= 2 * m)
            q = 2 * ONE;
        else
            q = (n * ONE) / m;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic bit clip_axis(longint d1, longint w1, longint d2, longint w2,
                                     output longint s, output longint e);
        bit in1;
        bit in2;
        longint ta;
        longint tb;
        longint lo;
        longint hi;
        longint b;
        in1 = magnitude(d1) <= magnitude(w1);
        in2 = magnitude(d2) <= magnitude(w2);
        s = 0;
        e = ONE;
        if (in1 && in2)
            return 1'b1;
        if ((d2 - d1) - (w2 - w1) == 0 || (d2 - d1) + (w2 - w1) == 0)
            return in1;
        ta = crossing(w1 - d1, (d2 - d1) - (w2 - w1));
        tb = crossing(-(w1 + d1), (d2 - d1) + (w2 - w1));
        lo = ta < tb ? ta : tb;
        hi = ta < tb ? tb : ta;
        if (lo >= 0 && hi <= ONE)
        begin
            s = lo;
            e = hi;
            return 1'b1;
        end
        if (hi <= 0 || lo >= ONE || (lo <= 0 && hi >= ONE))
            return in1;
        b = lo >= 0 ? lo : hi;
        if (in1)
            e = b;
        else
            s = b;
        return 1'b1;
    endfunction

    function automatic clip_result_t predict_clip(logic [hlc_pkg::IN_W-1:0] seg);
        clip_result_t r;
        longint c[8];
        longint ts;
        longint te;
        longint s;
        longint e;
        bit vis;
        for (int i = 0; i < 8; i++)
            c[i] = longint'($signed(seg[i*CW +: CW]));
        ts = 0;
        te = ONE;
        vis = 1'b1;
        for (int a = 0; a < hlc_pkg::NAXES; a++)
        begin
            if (vis)
            begin
                if (!clip_axis(c[a], c[3], c[4+a], c[7], s, e))
                    vis = 1'b0;
                else
                begin
                    if (s > ts) ts = s;
                    if (e < te) te = e;
                end
            end
        end
        if (vis && ts > te)
            vis = 1'b0;
        r.vis  = vis;
        r.t_lo = vis ? QW'(ts) : '0;
        r.t_hi = vis ? QW'(te) : '0;
        return r;
    endfunction

    assign pending = expected_clips.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            checked    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_clips.push_back(predict_clip(s_tdata));
            if (m_tvalid && m_tready)
            begin
                clip_result_t got;
                clip_result_t want;
                got = m_tdata[2*QW:0];
                checked <= checked + 1;
                if (expected_clips.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result transaction %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_clips.pop_front();
                    if (got !== want || m_tdata[hlc_pkg::OUT_W-1:2*QW+1] !== '0)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: visible %0d/%0d start %0d/%0d end %0d/%0d",
                                     want.vis, got.vis, want.t_lo, got.t_lo,
                                     want.t_hi, got.t_hi);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the homogeneous line clip unit
// Drives directed and random segments with random gaps, and stalls the output
// for random ones; the checker by the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_SEGMENTS = 1530;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int CW = hlc_pkg::COORD_W;
    localparam longint C_MAX = 64'sh7fffffff;
    localparam longint C_MIN = -64'sh80000000;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [hlc_pkg::IN_W-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [hlc_pkg::OUT_W-1:0] m_tdata;
    int                        fail_count;
    int                        pending;
    int                        checked;
    longint                    cycles;
    int                        visible_seen;
    bit                        stall_enable;

    homogeneous_line_clip_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    line_clip_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cycles       <= 0;
            visible_seen <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (m_tvalid && m_tready && m_tdata[0])
                visible_seen <= visible_seen + 1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("testbench failed");
                $finish;
            end
        end
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // The receiver stalls in bursts, with long stretches of full readiness.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!stall_enable)
                m_tready <= 1'b1;
            else
            begin
                stall = gap_length();
                m_tready <= (stall == 0);
                repeat (stall) @(negedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_segment(input logic [hlc_pkg::IN_W-1:0] seg);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seg;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [hlc_pkg::IN_W-1:0] pack_segment(longint c[8]);
        logic [hlc_pkg::IN_W-1:0] seg;
        for (int i = 0; i < 8; i++)
            seg[i*CW +: CW] = CW'(c[i]);
        return seg;
    endfunction

    function automatic longint coord_near(longint w);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7)
            return w * $signed($urandom_range(0, 600) - 300) / 100
                   + $signed($urandom_range(0, 20) - 10);
        if (kind < 9)
            return (kind == 7) ? w : -w;
        return longint'($signed($urandom()));
    endfunction

    // Mostly segments around the view volume so that crossings land in [0,1].
    function automatic logic [hlc_pkg::IN_W-1:0] random_segment();
        longint c[8];
        int style;
        style = $urandom_range(0, 9);
        if (style == 0)
        begin
            for (int i = 0; i < 8; i++)
                c[i] = longint'($signed($urandom()));
        end
        else
        begin
            c[3] = (style < 8) ? longint'($urandom_range(1, 1 << 20))
                               : longint'($signed($urandom()));
            c[7] = (style < 6) ? c[3] + $signed($urandom_range(0, 4096) - 2048)
                               : longint'($signed($urandom()) >>> $urandom_range(0, 12));
            if (c[7] > C_MAX) c[7] = C_MAX;
            for (int a = 0; a < 3; a++)
            begin
                c[a]   = coord_near(c[3]);
                c[4+a] = coord_near(c[7]);
                if (c[a] > C_MAX || c[a] < C_MIN) c[a] = c[3];
                if (c[4+a] > C_MAX || c[4+a] < C_MIN) c[4+a] = c[7];
            end
        end
        return pack_segment(c);
    endfunction

    task automatic send_coords(input longint c[8]);
        send_segment(pack_segment(c));
    endtask

    initial
    begin
        longint one;
        longint maxv;
        longint minv;
        one  = 65536;
        maxv = C_MAX;
        minv = C_MIN;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        stall_enable = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Both ends inside, then both outside on the same side.
        send_coords('{0, 0, 0, one, one/2, 0, 0, one});
        send_coords('{3*one, 0, 0, one, 4*one, 0, 0, one});
        // Crossing of the positive plane only, from inside and from outside.
        send_coords('{0, 0, 0, one, 3*one, 0, 0, one});
        send_coords('{3*one, 0, 0, one, 0, 0, 0, one});
        // Straddling both planes, and crossings on all three axes.
        send_coords('{-3*one, 0, 0, one, 3*one, 0, 0, one});
        send_coords('{-2*one, -3*one, 2*one, one, 2*one, 3*one, -5*one, one});
        // Parallel to a plane: inside and outside.
        send_coords('{one, 0, 0, one, 2*one, 0, 0, 2*one});
        send_coords('{2*one, 0, 0, one, 3*one, 0, 0, 2*one});
        // Negative w and zero w.
        send_coords('{0, 0, 0, -one, 3*one, 0, 0, -one});
        send_coords('{0, 0, 0, 0, 0, 0, 0, 0});
        send_coords('{one, 0, 0, 0, -one, 0, 0, 0});
        // Per-axis intervals that meet in one point: start equals end.
        send_coords('{-3*one, 3*one, 0, one, 3*one, -9*one, 0, one});
        // Saturating crossings and field extremes.
        send_coords('{minv, maxv, minv, maxv, maxv, minv, maxv, minv});
        send_coords('{maxv, maxv, maxv, maxv, minv, minv, minv, minv});
        send_coords('{minv, minv, minv, minv, maxv, maxv, maxv, maxv});
        send_coords('{-1, -1, -1, -1, -1, -1, -1, -1});
        send_coords('{1, 0, 0, 1, 0, 1, 0, 1});
        send_coords('{0, 0, 0, one, one, 0, 0, 0});
        send_segment({hlc_pkg::IN_W{1'b1}});
        send_segment('0);

        stall_enable = 1'b1;
        for (int i = 0; i < RANDOM_SEGMENTS; i++)
        begin
            send_segment(random_segment());
            if (i == RANDOM_SEGMENTS / 2)
            begin
                // Drain the pipeline before continuing.
                s_tvalid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
        $display("checked %0d clip results, %0d of them visible", checked, visible_seen);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

### homogeneous_line_clip_unit.f
design/hlc_pkg.sv
design/hlc_front.sv
design/hlc_fifo.sv
design/hlc_div.sv
design/hlc_back.sv
design/homogeneous_line_clip_unit.sv
tb/line_clip_checker.sv
tb/testbench.sv
